@@ sv/usf_pkg.sv @@
// shared types, codes and helpers for the ultrasonic serial frame median hold block
// no dependencies; imported by every module of the block
package usf_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned DIST_W  = 16;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned PHASE_W = 2;

    // item kind carried on tuser
    localparam logic CMD_BYTE      = 1'b0;
    localparam logic CMD_FRAME_END = 1'b1;

    // register map
    localparam int unsigned PADDR_W        = 2;
    localparam logic [PADDR_W-1:0] ADDR_MISS_LIMIT = 2'd0;
    localparam logic [BYTE_W-1:0]  MISS_LIMIT_RESET = 8'd5;

    // byte counts per frame and last phase of the median group
    localparam logic [COUNT_W-1:0] FRAME_MAX_BYTES = 3'd4;
    localparam logic [COUNT_W-1:0] FRAME_CHECKED   = 3'd3;
    localparam logic [COUNT_W-1:0] FRAME_PLAIN     = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_LAST      = 2'd2;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              crc_err;
    } t_frame_res;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] median;
        logic [DIST_W-1:0] held;
        logic [BYTE_W-1:0] misses;
    } t_reading;

    function automatic logic [DIST_W-1:0] median3(
        input logic [DIST_W-1:0] a,
        input logic [DIST_W-1:0] b,
        input logic [DIST_W-1:0] c
    );
        logic [DIST_W-1:0] lo;
        logic [DIST_W-1:0] hi;
        logic [DIST_W-1:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c < lo) begin
            m = lo;
        end else if (c > hi) begin
            m = hi;
        end else begin
            m = c;
        end
        return m;
    endfunction

endpackage

@@ sv/usf_frame.sv @@
// frame byte store and decoder: collects up to four bytes, decodes distance at frame end
// depends on usf_pkg
module usf_frame (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic                      i_cmd,
    input  logic [usf_pkg::BYTE_W-1:0] i_byte,
    output usf_pkg::t_frame_res       o_res
);
    import usf_pkg::*;

    logic [BYTE_W-1:0]  r_bytes [4];
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [BYTE_W-1:0]  w_sum;

    // 8-bit sum wraps naturally
    assign w_sum = r_bytes[0] + r_bytes[1] + r_bytes[2];

    always_comb begin
        o_res.distance = '0;
        o_res.crc_err  = 1'b0;
        if (r_count >= FRAME_CHECKED) begin
            if (w_sum == r_bytes[3]) begin
                o_res.distance = {r_bytes[1], r_bytes[2]};
            end else begin
                o_res.crc_err = 1'b1;
            end
        end else if (r_count == FRAME_PLAIN) begin
            o_res.distance = {r_bytes[0], r_bytes[1]};
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_step) begin
            if (i_cmd == CMD_FRAME_END) begin
                n_count = '0;
            end else if (r_count < FRAME_MAX_BYTES) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // payload store, no reset
    always_ff @(posedge i_clk) begin
        if (i_step && i_cmd == CMD_BYTE && r_count < FRAME_MAX_BYTES) begin
            r_bytes[r_count[1:0]] <= i_byte;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FRAME_MAX_BYTES)
        else $error("frame byte count beyond four");

endmodule

@@ sv/usf_hold.sv @@
// three-frame median and held distance with miss countdown
// depends on usf_pkg
module usf_hold (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_frame_end,
    input  logic [usf_pkg::DIST_W-1:0] i_dist,
    input  logic [usf_pkg::BYTE_W-1:0] i_miss_limit,
    output usf_pkg::t_reading          o_rd
);
    import usf_pkg::*;

    logic [DIST_W-1:0]  r_earlier [2];
    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;
    logic [DIST_W-1:0]  r_held;
    logic [DIST_W-1:0]  n_held;
    logic [BYTE_W-1:0]  r_miss;
    logic [BYTE_W-1:0]  n_miss;
    logic               w_last;
    logic [DIST_W-1:0]  w_med;

    assign w_last = (r_phase >= PHASE_LAST);
    assign w_med  = median3(r_earlier[0], r_earlier[1], i_dist);

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_miss  = r_miss;
        if (i_frame_end) begin
            if (w_last) begin
                n_phase = '0;
                if (r_miss != '0) begin
                    n_miss = r_miss - 1'b1;
                end else begin
                    n_held = '0;
                end
                if (w_med != '0) begin
                    n_held = w_med;
                    n_miss = i_miss_limit;
                end
            end else begin
                n_phase = r_phase + 1'b1;
            end
        end
    end

    always_comb begin
        o_rd.done   = w_last;
        o_rd.median = w_last ? w_med : '0;
        o_rd.held   = n_held;
        o_rd.misses = n_miss;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_held  <= '0;
            r_miss  <= '0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_miss  <= n_miss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame_end && !w_last) begin
            r_earlier[r_phase[0]] <= i_dist;
        end
    end

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PHASE_LAST)
        else $error("median phase beyond third frame");

    a_nonzero_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frame_end && w_last && w_med != '0 |=> r_held == $past(w_med)
            && r_miss == $past(i_miss_limit))
        else $error("nonzero median did not reload held distance");

endmodule

@@ sv/ultrasonic_serial_frame_median_hold.sv @@
// top level of the ultrasonic serial frame decoder with median hold
// depends on usf_pkg, usf_frame and usf_hold
//
// Takes one beat per clock unless a frame end is stalled: a received serial byte
// (tuser = 0) or a frame-end event (tuser = 1). Byte beats give no result; each
// frame-end beat gives one result beat, via the input and then the result register,
// carrying the frame distance, the checksum and reading flags, the median of the
// last three frames on every third frame, and the held distance with its miss
// countdown. Beats are taken back to back; a frame-end beat waits in the input register
// only while the result register is full and the far side is not ready, the single
// result register being the only limit. miss_limit (address 0, reset 5) is written over
// the register port; the user must write it only while the block is idle (not enforced).
module ultrasonic_serial_frame_median_hold (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,   // [7:0] rx_byte
    input  logic [0:0]                  i_s_tuser,   // [0] command
    // result stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [15:0] frame_distance_mm, [31:16] median_mm, [47:32] held_distance_mm,
    // [55:48] misses_left
    output logic [55:0]                 o_m_tdata,
    output logic [1:0]                  o_m_tuser,   // [0] checksum_error, [1] reading_done
    // register port
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [usf_pkg::PADDR_W-1:0] i_paddr,
    input  logic [31:0]                 i_pwdata,
    output logic [31:0]                 o_prdata,
    output logic                        o_pready
);
    import usf_pkg::*;

    // input register
    logic              r_in_valid;
    logic              r_in_cmd;
    logic [BYTE_W-1:0] r_in_byte;
    // result register
    logic              r_out_valid;
    logic [55:0]       r_out_data;
    logic [1:0]        r_out_user;
    // configuration
    logic [BYTE_W-1:0] r_miss_limit;

    logic       w_in_take;
    logic       w_advance;
    logic       w_frame_end;
    t_frame_res w_frame;
    t_reading   w_rd;

    // a byte beat never needs the result register; a frame end needs it free
    // or draining this cycle
    assign w_advance   = r_in_valid && (r_in_cmd == CMD_BYTE || !r_out_valid || i_m_tready);
    assign w_frame_end = w_advance && r_in_cmd == CMD_FRAME_END;
    assign o_s_tready  = !r_in_valid || w_advance;
    assign w_in_take   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_cmd  <= i_s_tuser[0];
            r_in_byte <= i_s_tdata;
        end
    end

    usf_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_cmd   (r_in_cmd),
        .i_byte  (r_in_byte),
        .o_res   (w_frame)
    );

    usf_hold u_hold (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame_end  (w_frame_end),
        .i_dist       (w_frame.distance),
        .i_miss_limit (r_miss_limit),
        .o_rd         (w_rd)
    );

    // result register, loads on frame end, empties when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_frame_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_frame_end) begin
            r_out_data <= {w_rd.misses, w_rd.held, w_rd.median, w_frame.distance};
            r_out_user <= {w_rd.done, w_frame.crc_err};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    // register port, no wait states
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_limit <= MISS_LIMIT_RESET;
        end else if (i_psel && i_penable && i_pwrite && o_pready
                     && i_paddr == ADDR_MISS_LIMIT) begin
            r_miss_limit <= i_pwdata[BYTE_W-1:0];
        end
    end

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr == ADDR_MISS_LIMIT) ? {24'd0, r_miss_limit} : 32'd0;

    // a stalled frame end stays in the input register
    a_frame_end_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_cmd == CMD_FRAME_END && r_out_valid && !i_m_tready
            |=> r_in_valid && r_in_cmd == CMD_FRAME_END)
        else $error("stalled frame end lost from input register");

    // every new result comes from a frame end that advanced
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_frame_end))
        else $error("result raised without a frame end");

endmodule
